// File: design/gsa_pkg.sv
`default_nettype none

package gsa_pkg;

    localparam int TIME_WIDTH_DEF     = 32;
    localparam int ADAPT_PRIORITY_DEF = 7;

    localparam int FIELD_W = 32;
    localparam int SUM_W   = FIELD_W + 1;
    localparam int PRIO_W  = 3;
    localparam int CFG_IDX_W = 3;

    // divide by ten: exact for any 32 bit value
    localparam logic [31:0] DIV10_MUL = 32'hCCCC_CCCD;
    localparam int          DIV10_SH  = 35;
    localparam int          DIV10_W   = FIELD_W - 3;

    // floor to microseconds as (t >> 3) / 125, exact below 2^30
    localparam int          US_SHIFT   = 3;
    localparam int          US_N_W     = SUM_W - US_SHIFT;
    localparam logic [30:0] DIV125_MUL = 31'd1099511628;
    localparam int          DIV125_SH  = 37;
    localparam int          US_Q_W     = US_N_W + 31 - DIV125_SH;
    localparam int          NS_PER_US  = 1000;
    localparam int          TT_W       = US_Q_W + 10;

    localparam logic [31:0] CYCLE_TIME_RST     = 32'd1000000;
    localparam logic [31:0] INCREASE_STEP_RST  = 32'd1000;
    localparam logic [31:0] DECREASE_STEP_RST  = 32'd1000;
    localparam logic [31:0] MAX_INC_STEP_RST   = 32'd10000;
    localparam logic [31:0] MAX_DEC_STEP_RST   = 32'd10000;
    localparam logic [31:0] UPPER_LIMIT_RST    = 32'd100000;
    localparam logic [31:0] LOWER_LIMIT_RST    = 32'd50000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CYCLE_TIME    = 3'd0,
        CFG_INCREASE_STEP = 3'd1,
        CFG_DECREASE_STEP = 3'd2,
        CFG_MAX_INC_STEP  = 3'd3,
        CFG_MAX_DEC_STEP  = 3'd4,
        CFG_UPPER_LIMIT   = 3'd5,
        CFG_LOWER_LIMIT   = 3'd6,
        CFG_AUTO_ENABLE   = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_INC  = 3'd1,
        ACT_AUTO = 3'd2,
        ACT_DEC  = 3'd3,
        ACT_HOLD = 3'd4
    } t_action;

    typedef struct packed {
        logic [PRIO_W-1:0]  priority_req;
        logic [FIELD_W-1:0] frame_delay;
        logic [FIELD_W-1:0] pending_interval;
        logic [FIELD_W-1:0] running_interval;
        logic               already_increased;
        logic [FIELD_W-1:0] last_tt_offset;
    } t_gsa_in;

    typedef struct packed {
        logic [FIELD_W-1:0] tt_interval;
        logic [FIELD_W-1:0] other_interval;
        logic               set_increased;
        t_action            action;
    } t_gsa_out;

    typedef struct packed {
        logic    adapt;
        t_action action;
    } t_gsa_tag;

    // floor(9r/10) and ceil(9r/10) for a remainder of a division by ten
    function automatic logic [3:0] ninety_lo(input logic [3:0] rem);
        logic [3:0] res;
        case (rem)
            4'd0: res = 4'd0;
            4'd1: res = 4'd0;
            4'd2: res = 4'd1;
            4'd3: res = 4'd2;
            4'd4: res = 4'd3;
            4'd5: res = 4'd4;
            4'd6: res = 4'd5;
            4'd7: res = 4'd6;
            4'd8: res = 4'd7;
            4'd9: res = 4'd8;
            default: res = 4'd0;
        endcase
        return res;
    endfunction

    function automatic logic [3:0] ninety_hi(input logic [3:0] rem);
        logic [3:0] res;
        case (rem)
            4'd0: res = 4'd0;
            4'd1: res = 4'd1;
            4'd2: res = 4'd2;
            4'd3: res = 4'd3;
            4'd4: res = 4'd4;
            4'd5: res = 4'd5;
            4'd6: res = 4'd6;
            4'd7: res = 4'd7;
            4'd8: res = 4'd8;
            4'd9: res = 4'd9;
            default: res = 4'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/tsn_gate_slot_adaptation_unit.sv
// Time-triggered gate slot adaptation.
// Each word on the input carries one received frame: its priority, delay,
// the pending and running time-triggered intervals, the increased flag and
// the last time-triggered transmission offset. The block answers with the new
// time-triggered interval floored to whole microseconds, its complement within
// the cycle, the set-increased flag and the action code.
// Input: a word is taken at a clock edge with start high and busy low. busy
// stays low: the pipeline takes a word every cycle.
// Output: one result word per input word, shown for one cycle with o_done high,
// in order. The receiver cannot stall, so nothing is held back.
// Throughput: one word per cycle; six register stages: path decode with the
// divisions by ten, candidate targets, target selection, division by one
// thousand, rescale to nanoseconds, complement.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx at the
// clock edge; write only while no word is in flight.
// Reset: synchronous, active low; clears the pipeline valid bits and loads the
// default configuration.
`default_nettype none

module tsn_gate_slot_adaptation_unit #(
    parameter int TIME_WIDTH     = gsa_pkg::TIME_WIDTH_DEF,
    parameter int ADAPT_PRIORITY = gsa_pkg::ADAPT_PRIORITY_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  gsa_pkg::t_gsa_in             i_item,
    input  wire                          i_cfg_we,
    input  wire [gsa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [gsa_pkg::FIELD_W-1:0]   i_cfg_wdata,
    output logic                         o_done,
    output gsa_pkg::t_gsa_out            o_result
);
    import gsa_pkg::*;

    localparam int SAT_BITS = (TIME_WIDTH < SUM_W) ? TIME_WIDTH : SUM_W;
    localparam logic [SUM_W-1:0] TMAX_S = {SUM_W{1'b1}} >> (SUM_W - SAT_BITS);
    localparam logic [PRIO_W-1:0] ADAPT_CODE = PRIO_W'(ADAPT_PRIORITY);
    localparam int LATENCY = 6;

    function automatic logic [SUM_W-1:0] sat_add(input logic [FIELD_W-1:0] a,
                                                 input logic [FIELD_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        return (s > TMAX_S) ? TMAX_S : s;
    endfunction

    logic [FIELD_W-1:0] r_cycle_time;
    logic [FIELD_W-1:0] r_increase_step;
    logic [FIELD_W-1:0] r_decrease_step;
    logic [FIELD_W-1:0] r_max_inc_step;
    logic [FIELD_W-1:0] r_max_dec_step;
    logic [FIELD_W-1:0] r_upper_limit;
    logic [FIELD_W-1:0] r_lower_limit;
    logic               r_auto_enable;

    logic w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_time    <= CYCLE_TIME_RST;
            r_increase_step <= INCREASE_STEP_RST;
            r_decrease_step <= DECREASE_STEP_RST;
            r_max_inc_step  <= MAX_INC_STEP_RST;
            r_max_dec_step  <= MAX_DEC_STEP_RST;
            r_upper_limit   <= UPPER_LIMIT_RST;
            r_lower_limit   <= LOWER_LIMIT_RST;
            r_auto_enable   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CYCLE_TIME:    r_cycle_time    <= i_cfg_wdata;
                CFG_INCREASE_STEP: r_increase_step <= i_cfg_wdata;
                CFG_DECREASE_STEP: r_decrease_step <= i_cfg_wdata;
                CFG_MAX_INC_STEP:  r_max_inc_step  <= i_cfg_wdata;
                CFG_MAX_DEC_STEP:  r_max_dec_step  <= i_cfg_wdata;
                CFG_UPPER_LIMIT:   r_upper_limit   <= i_cfg_wdata;
                CFG_LOWER_LIMIT:   r_lower_limit   <= i_cfg_wdata;
                CFG_AUTO_ENABLE:   r_auto_enable   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // stage 1: path decode, divisions by ten, step arithmetic
    logic                 r1_vld;
    t_gsa_tag             r1_tag;
    logic [FIELD_W-1:0]   r1_peak;
    logic [FIELD_W-1:0]   r1_off;
    logic [DIV10_W-1:0]   r1_off10;
    logic [DIV10_W-1:0]   r1_c10;
    logic                 r1_pend_lo;
    logic [FIELD_W-1:0]   r1_pend_m;
    logic [SUM_W-1:0]     r1_run_cap;
    logic [FIELD_W-1:0]   r1_run_dec;
    logic [FIELD_W-1:0]   r1_running;
    logic [FIELD_W-1:0]   r1_pending;

    t_gsa_tag             n1_tag;
    logic [2*FIELD_W-1:0] w1_off_prod;
    logic [2*FIELD_W-1:0] w1_c_prod;
    logic                 w1_inc;
    logic                 w1_auto;
    logic                 w1_dec;

    always_comb begin
        w1_off_prod = (2*FIELD_W)'(i_item.last_tt_offset) * (2*FIELD_W)'(DIV10_MUL);
        w1_c_prod   = (2*FIELD_W)'(r_cycle_time) * (2*FIELD_W)'(DIV10_MUL);
        w1_inc  = i_item.frame_delay > r_upper_limit;
        w1_auto = !w1_inc && r_auto_enable && !i_item.already_increased;
        w1_dec  = !w1_inc && !w1_auto && !i_item.already_increased &&
                  (i_item.frame_delay <= r_lower_limit);
        n1_tag.adapt = (i_item.priority_req == ADAPT_CODE);
        if (w1_inc) begin
            n1_tag.action = ACT_INC;
        end else if (w1_auto) begin
            n1_tag.action = ACT_AUTO;
        end else if (w1_dec) begin
            n1_tag.action = ACT_DEC;
        end else begin
            n1_tag.action = ACT_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= w_accept;
        end
        r1_tag     <= n1_tag;
        r1_peak    <= (i_item.pending_interval < i_item.running_interval) ?
                      i_item.running_interval : i_item.pending_interval;
        r1_off     <= i_item.last_tt_offset;
        r1_off10   <= w1_off_prod[DIV10_SH +: DIV10_W];
        r1_c10     <= w1_c_prod[DIV10_SH +: DIV10_W];
        r1_pend_lo <= i_item.pending_interval < r_decrease_step;
        r1_pend_m  <= i_item.pending_interval - r_decrease_step;
        r1_run_cap <= sat_add(i_item.running_interval, r_max_inc_step);
        r1_run_dec <= (i_item.running_interval > r_max_dec_step) ?
                      i_item.running_interval - r_max_dec_step : '0;
        r1_running <= i_item.running_interval;
        r1_pending <= i_item.pending_interval;
    end

    // stage 2: remainder of the cycle, candidate targets
    logic                 r2_vld;
    t_gsa_tag             r2_tag;
    logic [FIELD_W-1:0]   r2_c10;
    logic [3:0]           r2_rem;
    logic [FIELD_W-1:0]   r2_c9;
    logic [SUM_W-1:0]     r2_inc_t;
    logic [SUM_W-1:0]     r2_auto_t;
    logic                 r2_dec_floor;
    logic                 r2_dec_cap;
    logic [SUM_W-1:0]     r2_run_cap;
    logic [FIELD_W-1:0]   r2_run_dec;
    logic [FIELD_W-1:0]   r2_pend_m;
    logic [FIELD_W-1:0]   r2_running;
    logic [FIELD_W-1:0]   r2_pending;

    logic [FIELD_W-1:0]   w2_c10;
    logic [FIELD_W-1:0]   w2_c10x10;
    logic [FIELD_W-1:0]   w2_rem;
    logic [FIELD_W-1:0]   w2_pdiff;

    always_comb begin
        w2_c10    = FIELD_W'(r1_c10);
        w2_c10x10 = (w2_c10 << 3) + (w2_c10 << 1);
        w2_rem    = r_cycle_time - w2_c10x10;
        w2_pdiff  = (r1_pend_m >= r1_running) ? r1_pend_m - r1_running :
                                                r1_running - r1_pend_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_tag       <= r1_tag;
        r2_c10       <= w2_c10;
        r2_rem       <= w2_rem[3:0];
        r2_c9        <= (w2_c10 << 3) + w2_c10;
        r2_inc_t     <= sat_add(r1_peak, r_increase_step);
        r2_auto_t    <= sat_add(r1_off, FIELD_W'(r1_off10));
        r2_dec_floor <= r1_pend_lo || (r1_pend_m <= w2_c10);
        r2_dec_cap   <= w2_pdiff >= r_max_dec_step;
        r2_run_cap   <= r1_run_cap;
        r2_run_dec   <= r1_run_dec;
        r2_pend_m    <= r1_pend_m;
        r2_running   <= r1_running;
        r2_pending   <= r1_pending;
    end

    // stage 3: clamps and target selection
    logic                 r3_vld;
    t_gsa_tag             r3_tag;
    logic [SUM_W-1:0]     r3_target;

    logic [FIELD_W-1:0]   w3_nf;
    logic [SUM_W-1:0]     w3_nc;
    logic [SUM_W-1:0]     w3_run_ext;
    logic [SUM_W-1:0]     w3_idiff;
    logic [SUM_W-1:0]     w3_inc_sel;
    logic [SUM_W-1:0]     w3_dec_sel;
    logic [SUM_W-1:0]     n3_target;

    always_comb begin
        w3_nf      = r2_c9 + FIELD_W'(ninety_lo(r2_rem));
        w3_nc      = SUM_W'(r2_c9) + SUM_W'(ninety_hi(r2_rem));
        w3_run_ext = SUM_W'(r2_running);
        w3_idiff   = (r2_inc_t >= w3_run_ext) ? r2_inc_t - w3_run_ext :
                                                w3_run_ext - r2_inc_t;
        if (r2_inc_t >= w3_nc) begin
            w3_inc_sel = SUM_W'(w3_nf);
        end else if (w3_idiff >= SUM_W'(r_max_inc_step)) begin
            w3_inc_sel = r2_run_cap;
        end else begin
            w3_inc_sel = r2_inc_t;
        end
        if (r2_dec_floor) begin
            w3_dec_sel = SUM_W'(r2_c10);
        end else if (r2_dec_cap) begin
            w3_dec_sel = SUM_W'(r2_run_dec);
        end else begin
            w3_dec_sel = SUM_W'(r2_pend_m);
        end
        case (r2_tag.action)
            ACT_INC:  n3_target = w3_inc_sel;
            ACT_AUTO: n3_target = r2_auto_t;
            ACT_DEC:  n3_target = w3_dec_sel;
            default:  n3_target = SUM_W'(r2_pending);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_tag    <= r2_tag;
        r3_target <= n3_target;
    end

    // stages 4 to 6: floor to microseconds, rescale to nanoseconds, complement
    gsa_floor_us u_floor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (r3_vld),
        .i_target     (r3_target),
        .i_tag        (r3_tag),
        .i_cycle_time (r_cycle_time),
        .o_vld        (o_done),
        .o_result     (o_result)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_done)
        else $error("word taken without a result after the pipeline latency");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, LATENCY))
        else $error("result without a matching input word");

    a_inc_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.set_increased |-> o_result.action == ACT_INC)
        else $error("set_increased outside the increase path");

    a_complement: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.action != ACT_NONE |->
            (o_result.other_interval == '0) ||
            (SUM_W'(o_result.tt_interval) + SUM_W'(o_result.other_interval) ==
             SUM_W'(r_cycle_time)))
        else $error("intervals do not fill the cycle");

    a_untouched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.action == ACT_NONE |->
            o_result.tt_interval == '0 && o_result.other_interval == '0)
        else $error("non-adapting frame changed the schedule");

endmodule

`default_nettype wire

// File: design/gsa_floor_us.sv
`default_nettype none

module gsa_floor_us (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_vld,
    input  wire [gsa_pkg::SUM_W-1:0]   i_target,
    input  gsa_pkg::t_gsa_tag          i_tag,
    input  wire [gsa_pkg::FIELD_W-1:0] i_cycle_time,
    output logic                       o_vld,
    output gsa_pkg::t_gsa_out          o_result
);
    import gsa_pkg::*;

    localparam int PROD_W = US_N_W + 31;

    logic                 r_q_vld;
    logic [US_Q_W-1:0]    r_q;
    t_gsa_tag             r_q_tag;
    logic [US_Q_W-1:0]    n_q;
    logic [PROD_W-1:0]    w_prod;

    logic                 r_tt_vld;
    logic [TT_W-1:0]      r_tt;
    t_gsa_tag             r_tt_tag;
    logic [TT_W-1:0]      n_tt;

    logic                 r_out_vld;
    t_gsa_out             r_out;
    t_gsa_out             n_out;
    logic [TT_W-1:0]      w_cycle_ext;

    // quotient by microseconds
    always_comb begin
        w_prod = PROD_W'(i_target[SUM_W-1:US_SHIFT]) * PROD_W'(DIV125_MUL);
        n_q    = w_prod[DIV125_SH +: US_Q_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else begin
            r_q_vld <= i_vld;
        end
        r_q     <= n_q;
        r_q_tag <= i_tag;
    end

    always_comb begin
        n_tt = TT_W'(r_q) * TT_W'(NS_PER_US);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tt_vld <= 1'b0;
        end else begin
            r_tt_vld <= r_q_vld;
        end
        r_tt     <= n_tt;
        r_tt_tag <= r_q_tag;
    end

    // complement within the cycle, non-adapting words read as zero
    always_comb begin
        w_cycle_ext = TT_W'(i_cycle_time);
        n_out       = '0;
        if (r_tt_tag.adapt) begin
            n_out.tt_interval    = r_tt[FIELD_W-1:0];
            n_out.other_interval = (w_cycle_ext > r_tt) ?
                                   FIELD_W'(w_cycle_ext - r_tt) : '0;
            n_out.set_increased  = (r_tt_tag.action == ACT_INC);
            n_out.action         = r_tt_tag.action;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_tt_vld;
        end
        r_out <= n_out;
    end

    assign o_vld    = r_out_vld;
    assign o_result = r_out;

endmodule

`default_nettype wire

// File: bench/testbench.sv
`default_nettype none

import gsa_pkg::*;

typedef struct packed {
    logic [31:0] cycle_time;
    logic [31:0] inc_step;
    logic [31:0] dec_step;
    logic [31:0] max_inc;
    logic [31:0] max_dec;
    logic [31:0] upper_limit;
    logic [31:0] lower_limit;
    logic        auto_en;
} t_gate_cfg;

class gate_slot_scoreboard;
    localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF;

    t_gate_cfg regs;
    t_gsa_out  due_results[$];
    int        errors;
    int        checked;
    int        act_count[5];

    function new();
        regs = '{CYCLE_TIME_RST, INCREASE_STEP_RST, DECREASE_STEP_RST, MAX_INC_STEP_RST,
                 MAX_DEC_STEP_RST, UPPER_LIMIT_RST, LOWER_LIMIT_RST, 1'b0};
        errors = 0;
        checked = 0;
        foreach (act_count[k]) act_count[k] = 0;
    endfunction

    function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > TIME_MAX) ? TIME_MAX : s;
    endfunction

    function logic [63:0] gap_of(logic [63:0] a, logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function t_gsa_out predict_slot(t_gsa_in f);
        t_gsa_out    r;
        logic [63:0] c, tgt, base, lo_cut, hi_cut, tt, pend, run, off;
        c = 64'(regs.cycle_time);
        pend = 64'(f.pending_interval);
        run = 64'(f.running_interval);
        off = 64'(f.last_tt_offset);
        r = '0;
        r.action = ACT_NONE;
        if (f.priority_req != PRIO_W'(ADAPT_PRIORITY_DEF)) return r;
        tgt = pend;
        r.action = ACT_HOLD;
        lo_cut = (c * 9) / 10;
        hi_cut = (c * 9 + 9) / 10;
        if (f.frame_delay > regs.upper_limit) begin
            r.set_increased = 1'b1;
            r.action = ACT_INC;
            base = (pend < run) ? run : pend;
            tgt = sat_sum(base, 64'(regs.inc_step));
            if (tgt >= hi_cut) begin
                tgt = lo_cut;
            end else if (gap_of(tgt, run) >= 64'(regs.max_inc)) begin
                tgt = sat_sum(run, 64'(regs.max_inc));
            end
        end else if (regs.auto_en && !f.already_increased) begin
            r.action = ACT_AUTO;
            tgt = sat_sum(off, off / 10);
        end else if (f.frame_delay <= regs.lower_limit && !f.already_increased) begin
            r.action = ACT_DEC;
            if (pend < 64'(regs.dec_step) || pend - 64'(regs.dec_step) <= c / 10) begin
                tgt = c / 10;
            end else begin
                tgt = pend - 64'(regs.dec_step);
                if (gap_of(tgt, run) >= 64'(regs.max_dec))
                    tgt = (run > 64'(regs.max_dec)) ? run - 64'(regs.max_dec) : 64'd0;
            end
        end
        tt = (tgt / NS_PER_US) * NS_PER_US;
        r.tt_interval = tt[31:0];
        r.other_interval = (c > tt) ? 32'(c - tt) : 32'd0;
        return r;
    endfunction

    function void note_frame(t_gsa_in f);
        t_gsa_out r;
        r = predict_slot(f);
        act_count[int'(r.action)]++;
        due_results.push_back(r);
    endfunction

    function void check_word(t_gsa_out got, longint unsigned at_ns);
        t_gsa_out want;
        if (due_results.size() == 0) begin
            $display("%0d ns: result word with nothing due: tt %0d other %0d inc %0d act %0d",
                     at_ns, got.tt_interval, got.other_interval, got.set_increased,
                     got.action);
            errors++;
            return;
        end
        want = due_results.pop_front();
        checked++;
        if (got.tt_interval !== want.tt_interval) begin
            $display("%0d ns: tt_interval expected %0d got %0d",
                     at_ns, want.tt_interval, got.tt_interval);
            errors++;
        end
        if (got.other_interval !== want.other_interval) begin
            $display("%0d ns: other_interval expected %0d got %0d",
                     at_ns, want.other_interval, got.other_interval);
            errors++;
        end
        if (got.set_increased !== want.set_increased) begin
            $display("%0d ns: set_increased expected %0d got %0d",
                     at_ns, want.set_increased, got.set_increased);
            errors++;
        end
        if (got.action !== want.action) begin
            $display("%0d ns: action expected %0d got %0d", at_ns, want.action, got.action);
            errors++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 6;
    localparam int STALL_LIMIT = 400;
    localparam int MAX_GAP     = 60;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 45;
    localparam logic [2:0] TT_PRIO = PRIO_W'(ADAPT_PRIORITY_DEF);

    typedef enum int {SET_DEFAULT, SET_ALL_MIN, SET_ALL_MAX, SET_TYPICAL, SET_WIDE} t_set_kind;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_gsa_in   i_item = '0;
    logic      i_cfg_we = 1'b0;
    t_cfg_idx  i_cfg_idx = CFG_CYCLE_TIME;
    logic [31:0] i_cfg_wdata = '0;
    logic      o_done;
    t_gsa_out  o_result;

    gate_slot_scoreboard sb;
    t_gate_cfg active_cfg;
    int        stall_cnt = 0;
    int        settings_done = 0;
    int        frames_sent = 0;
    t_set_kind plan [PHASES] = '{SET_DEFAULT, SET_TYPICAL, SET_ALL_MIN, SET_TYPICAL, SET_ALL_MAX,
                                 SET_TYPICAL, SET_WIDE, SET_TYPICAL, SET_TYPICAL};

    tsn_gate_slot_adaptation_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_word(o_result, $time);
        if ((start && !busy) || o_done) begin
            stall_cnt = 0;
        end else begin
            stall_cnt++;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results still due",
                     stall_cnt, sb.due_results.size());
            $display("** tsn_gate_slot_adaptation_unit: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] clamp32(longint v);
        if (v < 0) return 32'd0;
        if (v > longint'(32'hFFFF_FFFF)) return 32'hFFFF_FFFF;
        return v[31:0];
    endfunction

    function automatic logic [31:0] near(logic [31:0] base, int unsigned spread);
        int unsigned s;
        s = (spread > (1 << 28)) ? (1 << 28) : spread;
        return clamp32(longint'(base) + longint'($urandom_range(0, 2 * s)) - longint'(s));
    endfunction

    function automatic logic [31:0] nonzero32();
        logic [31:0] v;
        v = $urandom;
        return (v == 0) ? 32'd1 : v;
    endfunction

    function automatic t_gate_cfg make_setting(t_set_kind kind);
        t_gate_cfg s;
        case (kind)
            SET_DEFAULT: begin
                s = '{CYCLE_TIME_RST, INCREASE_STEP_RST, DECREASE_STEP_RST, MAX_INC_STEP_RST,
                      MAX_DEC_STEP_RST, UPPER_LIMIT_RST, LOWER_LIMIT_RST, 1'b0};
            end
            SET_ALL_MIN: begin
                s = '{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 1'b0};
            end
            SET_ALL_MAX: begin
                s = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0};
            end
            SET_TYPICAL: begin
                s.cycle_time  = $urandom_range(20000, 2000000);
                s.inc_step    = $urandom_range(1, 5000);
                s.dec_step    = $urandom_range(1, 5000);
                s.max_inc     = $urandom_range(1, 20000);
                s.max_dec     = $urandom_range(1, 20000);
                s.upper_limit = $urandom_range(1000, 200000);
                s.lower_limit = $urandom_range(1, s.upper_limit);
                s.auto_en     = 1'($urandom_range(0, 1));
            end
            default: begin
                s.cycle_time  = nonzero32();
                s.inc_step    = nonzero32();
                s.dec_step    = nonzero32();
                s.max_inc     = nonzero32();
                s.max_dec     = nonzero32();
                s.upper_limit = nonzero32();
                s.lower_limit = nonzero32();
                s.auto_en     = 1'($urandom_range(0, 1));
            end
        endcase
        return s;
    endfunction

    function automatic t_gsa_in mk_frame(logic [2:0] prio, logic [31:0] delay, logic [31:0] pend,
                                         logic [31:0] run, logic inc, logic [31:0] off);
        t_gsa_in f;
        f.priority_req      = prio;
        f.frame_delay       = delay;
        f.pending_interval  = pend;
        f.running_interval  = run;
        f.already_increased = inc;
        f.last_tt_offset    = off;
        return f;
    endfunction

    function automatic t_gsa_in rand_frame();
        t_gsa_in     f;
        logic [31:0] c, c9, c1;
        int unsigned spread;
        c  = active_cfg.cycle_time;
        c9 = 32'((64'(c) * 9) / 10);
        c1 = c / 10;
        spread = ((active_cfg.max_inc > active_cfg.max_dec) ? active_cfg.max_inc
                                                            : active_cfg.max_dec) + 1000;
        f.priority_req = ($urandom_range(0, 99) < 85) ? TT_PRIO : 3'($urandom_range(0, 7));
        case ($urandom_range(0, 5))
            0: f.frame_delay = near(active_cfg.upper_limit, 3);
            1: f.frame_delay = near(active_cfg.lower_limit, 3);
            2: f.frame_delay = $urandom;
            3: f.frame_delay = clamp32(longint'(active_cfg.upper_limit) + 1 +
                                       longint'($urandom_range(0, 100000)));
            4: f.frame_delay = $urandom_range(active_cfg.lower_limit, active_cfg.upper_limit);
            default: f.frame_delay = $urandom_range(0, active_cfg.lower_limit);
        endcase
        case ($urandom_range(0, 3))
            0: f.pending_interval = near(c9, active_cfg.inc_step + 2000);
            1: f.pending_interval = near(c1, active_cfg.dec_step + 2000);
            2: f.pending_interval = $urandom_range(0, c);
            default: f.pending_interval = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0, 1: f.running_interval = near(f.pending_interval, spread);
            2: f.running_interval = f.pending_interval;
            3: f.running_interval = $urandom_range(0, c);
            default: f.running_interval = $urandom;
        endcase
        f.already_increased = ($urandom_range(0, 99) < 25);
        case ($urandom_range(0, 5))
            0, 1: f.last_tt_offset = $urandom_range(0, c);
            2: f.last_tt_offset = near(32'd3904515724, 2000);
            3: f.last_tt_offset = 32'hFFFF_FFFF;
            default: f.last_tt_offset = $urandom;
        endcase
        return f;
    endfunction

    task automatic apply_setting(t_gate_cfg s);
        t_cfg_idx    idx;
        logic [31:0] val;
        for (int k = 0; k < 8; k++) begin
            idx = t_cfg_idx'(k);
            case (idx)
                CFG_CYCLE_TIME:    val = s.cycle_time;
                CFG_INCREASE_STEP: val = s.inc_step;
                CFG_DECREASE_STEP: val = s.dec_step;
                CFG_MAX_INC_STEP:  val = s.max_inc;
                CFG_MAX_DEC_STEP:  val = s.max_dec;
                CFG_UPPER_LIMIT:   val = s.upper_limit;
                CFG_LOWER_LIMIT:   val = s.lower_limit;
                default:           val = {31'($urandom), s.auto_en};
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idx;
            i_cfg_wdata <= val;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        active_cfg = s;
        sb.regs = s;
        settings_done++;
    endtask

    task automatic send_frame(t_gsa_in f, int idle_pct);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct && gap < MAX_GAP) begin
            start <= 1'b0;
            @(posedge i_clk);
            gap++;
        end
        start  <= 1'b1;
        i_item <= f;
        do @(posedge i_clk); while (busy);
        sb.note_frame(f);
        frames_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    initial begin
        int idle_pct;
        sb = new();
        active_cfg = sb.regs;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, the increase, decrease and hold branches and their clamps
        apply_setting(make_setting(SET_DEFAULT));
        send_frame(mk_frame(3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                            32'hFFFF_FFFF), 0);
        send_frame(mk_frame(3'd6, 32'd200000, 32'd300000, 32'd300000, 1'b0, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'd200000, 32'd200000, 32'd200000, 1'b0, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'd100001, 32'd899500, 32'd899500, 1'b0, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'd150000, 32'd300000, 32'd250000, 1'b0, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'd150000, 32'd100000, 32'd400000, 1'b1, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'd100000, 32'd123456, 32'd123456, 1'b0, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'd0, 32'd500000, 32'd500000, 1'b1, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'd0, 32'd500000, 32'd500000, 1'b0, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'd50000, 32'd100500, 32'd100500, 1'b0, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'd50001, 32'd100500, 32'd100500, 1'b0, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'd1, 32'd500, 32'd0, 1'b0, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'd1, 32'd500000, 32'd520000, 1'b0, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'd1, 32'd500000, 32'd5000, 1'b0, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'd75000, 32'd2000000, 32'd0, 1'b0, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0, 32'd0), 0);
        drain();

        // widest cycle with automatic adaptation enabled
        apply_setting('{32'hFFFF_FFFF, 32'd1000, 32'd1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFE, 32'd1, 1'b1});
        send_frame(mk_frame(TT_PRIO, 32'd0, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF), 0);
        send_frame(mk_frame(TT_PRIO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7, 1'b0, 32'd0), 0);
        send_frame(mk_frame(TT_PRIO, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, 32'd12345), 0);
        send_frame(mk_frame(TT_PRIO, 32'hFFFF_FFFE, 32'd0, 32'd0, 1'b0, 32'd12345), 0);
        send_frame(mk_frame(TT_PRIO, 32'd2, 32'd5000, 32'd5000, 1'b0, 32'd0), 0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            idle_pct = (p < 3) ? 11 : (p < 6) ? 74 : 0;
            apply_setting(make_setting(plan[p]));
            for (int n = 0; n < PHASE_ITEMS; n++) send_frame(rand_frame(), idle_pct);
            drain();
        end

        $display("ran %0d frames over %0d register settings, %0d results checked",
                 frames_sent, settings_done, sb.checked);
        $display("actions: %0d untouched, %0d increase, %0d auto, %0d decrease, %0d hold",
                 sb.act_count[0], sb.act_count[1], sb.act_count[2], sb.act_count[3],
                 sb.act_count[4]);
        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("** tsn_gate_slot_adaptation_unit: PASSED **");
        end else begin
            $display("** tsn_gate_slot_adaptation_unit: FAILED **");
        end
        $finish;
    end
endmodule

`default_nettype wire

// File: files.f
design/gsa_pkg.sv
design/gsa_floor_us.sv
design/tsn_gate_slot_adaptation_unit.sv
bench/testbench.sv
